FILE: rtl/pmx_pkg.sv
package pmx_pkg;

    localparam int DATA_W         = 8;
    localparam int OFFSET_W       = 16;
    localparam int KEY_W          = 32;
    localparam int MAX_BODY_BYTES = 4096;

    localparam logic [DATA_W-1:0] VERSION_TAG      = 8'd65;
    localparam logic [KEY_W-1:0]  PACKET_KEY_RESET = 32'hB44BB44B;

    typedef enum logic
    {
        CFG_SESSION_KEY = 1'b0,
        CFG_PACKET_KEY  = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic                 body_valid;
        logic                 last;
        logic                 has_key;
        logic [DATA_W-1:0]    body_value;
        logic [OFFSET_W-1:0]  body_offset;
        logic [OFFSET_W-1:0]  size;
        logic [DATA_W-1:0]    neg_sum;
        logic [KEY_W-1:0]     start_key;
    } pmx_job_t;

endpackage

FILE: rtl/pmx_if.sv
interface pmx_in_if import pmx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface pmx_out_if import pmx_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   byte_value;
    logic [OFFSET_W-1:0] byte_offset;
    logic                end_of_packet;

    modport source (output valid, output byte_value, output byte_offset,
                    output end_of_packet, input ready);
    modport sink   (input valid, input byte_value, input byte_offset,
                    input end_of_packet, output ready);
endinterface

FILE: rtl/pmx_map_rom.sv
module pmx_map_rom import pmx_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DATA_W-1:0] addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam logic [DATA_W-1:0] MAP_MEM [256] = '{
        8'h70,8'h2F,8'h40,8'h5F,8'h44,8'h8E,8'h6E,8'h45,8'h7E,8'hAB,8'h2C,8'h1F,8'hB4,8'hAC,8'h9D,8'h91,
        8'h0D,8'h36,8'h9B,8'h0B,8'hD4,8'hC4,8'h39,8'h74,8'hBF,8'h23,8'h16,8'h14,8'h06,8'hEB,8'h04,8'h3E,
        8'h12,8'h5C,8'h8B,8'hBC,8'h61,8'h63,8'hF6,8'hA5,8'hE1,8'h65,8'hD8,8'hF5,8'h5A,8'h07,8'hF0,8'h13,
        8'hF2,8'h20,8'h6B,8'h4A,8'h24,8'h59,8'h89,8'h64,8'hD7,8'h42,8'h6A,8'h5E,8'h3D,8'h0A,8'h77,8'hE0,
        8'h80,8'h27,8'hB8,8'hC5,8'h8C,8'h0E,8'hFA,8'h8A,8'hD5,8'h29,8'h56,8'h57,8'h6C,8'h53,8'h67,8'h41,
        8'hE8,8'h00,8'h1A,8'hCE,8'h86,8'h83,8'hB0,8'h22,8'h28,8'h4D,8'h3F,8'h26,8'h46,8'h4F,8'h6F,8'h2B,
        8'h72,8'h3A,8'hF1,8'h8D,8'h97,8'h95,8'h49,8'h84,8'hE5,8'hE3,8'h79,8'h8F,8'h51,8'h10,8'hA8,8'h82,
        8'hC6,8'hDD,8'hFF,8'hFC,8'hE4,8'hCF,8'hB3,8'h09,8'h5D,8'hEA,8'h9C,8'h34,8'hF9,8'h17,8'h9F,8'hDA,
        8'h87,8'hF8,8'h15,8'h05,8'h3C,8'hD3,8'hA4,8'h85,8'h2E,8'hFB,8'hEE,8'h47,8'h3B,8'hEF,8'h37,8'h7F,
        8'h93,8'hAF,8'h69,8'h0C,8'h71,8'h31,8'hDE,8'h21,8'h75,8'hA0,8'hAA,8'hBA,8'h7C,8'h38,8'h02,8'hB7,
        8'h81,8'h01,8'hFD,8'hE7,8'h1D,8'hCC,8'hCD,8'hBD,8'h1B,8'h7A,8'h2A,8'hAD,8'h66,8'hBE,8'h55,8'h33,
        8'h03,8'hDB,8'h88,8'hB2,8'h1E,8'h4E,8'hB9,8'hE6,8'hC2,8'hF7,8'hCB,8'h7D,8'hC9,8'h62,8'hC3,8'hA6,
        8'hDC,8'hA7,8'h50,8'hB5,8'h4B,8'h94,8'hC0,8'h92,8'h4C,8'h11,8'h5B,8'h78,8'hD9,8'hB1,8'hED,8'h19,
        8'hE9,8'hA1,8'h1C,8'hB6,8'h32,8'h99,8'hA3,8'h76,8'h9E,8'h7B,8'h6D,8'h9A,8'h30,8'hD6,8'hA9,8'h25,
        8'hC7,8'hAE,8'h96,8'h35,8'hD0,8'hBB,8'hD2,8'hC8,8'hA2,8'h08,8'hF3,8'hD1,8'h73,8'hF4,8'h48,8'h2D,
        8'h90,8'hCA,8'hE2,8'h58,8'hC1,8'h18,8'h52,8'hFE,8'hDF,8'h68,8'h98,8'h54,8'hEC,8'h60,8'h43,8'h0F
    };

    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_reg <= MAP_MEM[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/pmx_cipher_core.sv
module pmx_cipher_core import pmx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    pmx_in_if.sink            plaintext,
    input  logic              cfg_write,
    input  cfg_index_t        cfg_index,
    input  logic [KEY_W-1:0]  cfg_data,
    output logic [DATA_W-1:0] rom_addr,
    output logic              rom_en,
    input  logic [DATA_W-1:0] rom_data,
    output logic              job_valid,
    input  logic              job_ready,
    output pmx_job_t          job
);

    localparam logic [31:0]         SEED_MUL  = 32'd241103;
    localparam logic [31:0]         SEED_ADD  = 32'd2533101;
    localparam logic [OFFSET_W-1:0] MAX_COUNT = OFFSET_W'(MAX_BODY_BYTES);
    localparam logic [DATA_W-1:0]   ROUND_STEP = 8'd3;

    function automatic logic [15:0] seed_map(input logic [15:0] seed);
        logic [31:0] h;
        h = 32'({16'd0, seed} * SEED_MUL) + SEED_ADD;
        return h[31:16];
    endfunction

    logic [KEY_W-1:0]    packet_key_reg;
    logic [KEY_W-1:0]    running_key_reg;
    logic [KEY_W-1:0]    start_key_reg;
    logic                first_done_reg;
    logic [OFFSET_W-1:0] count_reg;
    logic [DATA_W-1:0]   round_reg;
    logic [DATA_W-1:0]   sum_reg;
    logic [KEY_W-1:0]    word_reg;
    logic                s1_valid_reg;
    logic                key_pend_reg;

    logic                s1_counted_reg;
    logic                s1_last_reg;
    logic [OFFSET_W-1:0] s1_count_reg;
    logic [OFFSET_W-1:0] s1_count_after_reg;
    logic [DATA_W-1:0]   s1_neg_sum_reg;
    logic [KEY_W-1:0]    chain_word_reg;

    logic                accept;
    logic                counted;
    logic [DATA_W-1:0]   sum_next;
    logic [OFFSET_W-1:0] count_after;
    logic                exec;
    logic [KEY_W-1:0]    derived_key;
    logic [KEY_W-1:0]    key_eff;
    logic [1:0]          pos;
    logic [1:0]          flush_pos;
    logic [DATA_W-1:0]   cipher;
    logic [KEY_W-1:0]    word_new;
    logic [KEY_W-1:0]    word_cur;
    logic [KEY_W-1:0]    mask;
    logic                word_done;
    logic                flush_word;
    logic [KEY_W-1:0]    chain_word_next;
    logic                start_now;

    always_comb
    begin
        counted     = count_reg < MAX_COUNT;
        sum_next    = sum_reg + (counted ? plaintext.data_byte : '0);
        count_after = count_reg + OFFSET_W'(counted);

        derived_key = {seed_map(chain_word_reg[31:16]), seed_map(chain_word_reg[15:0])}
                      ^ packet_key_reg;
        key_eff     = key_pend_reg ? derived_key : running_key_reg;

        pos       = s1_count_reg[1:0];
        flush_pos = s1_count_after_reg[1:0];
        cipher    = rom_data ^ DATA_W'(key_eff >> {pos, 3'b000});

        word_new = (pos == 2'd0) ? '0 : word_reg;
        word_new[{pos, 3'b000} +: DATA_W] = cipher;
        word_cur = s1_counted_reg ? word_new : word_reg;

        unique case (flush_pos)
            2'd0: mask = 32'h0000_0000;
            2'd1: mask = 32'h0000_00FF;
            2'd2: mask = 32'h0000_FFFF;
            2'd3: mask = 32'h00FF_FFFF;
        endcase

        word_done       = s1_counted_reg && (pos == 2'd3);
        flush_word      = s1_last_reg && (flush_pos != 2'd0);
        chain_word_next = word_done ? word_new : ((word_cur & mask) | (key_eff & ~mask));
        start_now       = s1_counted_reg && (s1_count_reg == '0);

        job_valid = s1_valid_reg && (s1_counted_reg || s1_last_reg);
        exec      = s1_valid_reg && (job_ready || !(s1_counted_reg || s1_last_reg));
        accept    = plaintext.valid && plaintext.ready;

        job.body_valid  = s1_counted_reg;
        job.last        = s1_last_reg;
        job.has_key     = !first_done_reg;
        job.body_value  = cipher;
        job.body_offset = OFFSET_W'(4) + s1_count_reg
                          + ((!first_done_reg && (s1_count_reg[OFFSET_W-1:2] != '0))
                             ? OFFSET_W'(4) : '0);
        job.size        = OFFSET_W'(4) + s1_count_after_reg
                          + (first_done_reg ? '0 : OFFSET_W'(4));
        job.neg_sum     = s1_neg_sum_reg;
        job.start_key   = start_now ? key_eff : start_key_reg;
    end

    assign plaintext.ready = !s1_valid_reg || exec;
    assign rom_en          = accept;
    assign rom_addr        = plaintext.data_byte + round_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_key_reg  <= PACKET_KEY_RESET;
            running_key_reg <= '0;
            start_key_reg   <= '0;
            first_done_reg  <= 1'b0;
            count_reg       <= '0;
            round_reg       <= '0;
            sum_reg         <= '0;
            word_reg        <= '0;
            s1_valid_reg    <= 1'b0;
            key_pend_reg    <= 1'b0;
        end
        else
        begin
            if (key_pend_reg)
            begin
                running_key_reg <= derived_key;
            end

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_SESSION_KEY:
                    begin
                        if (!first_done_reg && (count_reg == '0))
                        begin
                            running_key_reg <= cfg_data;
                        end
                    end
                    CFG_PACKET_KEY:
                    begin
                        packet_key_reg <= cfg_data;
                    end
                endcase
            end

            if (accept)
            begin
                count_reg <= plaintext.last ? '0 : count_after;
                sum_reg   <= plaintext.last ? '0 : sum_next;
                if (counted)
                begin
                    round_reg <= round_reg + ROUND_STEP;
                end
            end

            key_pend_reg <= exec && (word_done || flush_word);

            if (exec)
            begin
                if (start_now)
                begin
                    start_key_reg <= key_eff;
                end
                if (s1_last_reg)
                begin
                    word_reg       <= '0;
                    first_done_reg <= 1'b1;
                end
                else if (s1_counted_reg)
                begin
                    word_reg <= word_new;
                end
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (exec)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_counted_reg     <= counted;
            s1_last_reg        <= plaintext.last;
            s1_count_reg       <= count_reg;
            s1_count_after_reg <= count_after;
            s1_neg_sum_reg     <= DATA_W'(0) - sum_next;
        end
        if (exec && (word_done || flush_word))
        begin
            chain_word_reg <= chain_word_next;
        end
    end

endmodule

FILE: rtl/pmx_emitter.sv
module pmx_emitter import pmx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  pmx_job_t job,
    pmx_out_if.source ciphertext
);

    typedef enum logic [3:0]
    {
        STEP_BODY,
        STEP_SIZE_LO,
        STEP_SIZE_HI,
        STEP_SUM,
        STEP_VERSION,
        STEP_KEY0,
        STEP_KEY1,
        STEP_KEY2,
        STEP_KEY3
    } step_t;

    logic     busy_reg;
    step_t    step_reg;
    pmx_job_t job_reg;

    step_t    step_next;
    step_t    last_step;
    step_t    first_step;
    logic     done;
    logic     take;

    always_comb
    begin
        unique case (step_reg)
            STEP_BODY:    step_next = STEP_SIZE_LO;
            STEP_SIZE_LO: step_next = STEP_SIZE_HI;
            STEP_SIZE_HI: step_next = STEP_SUM;
            STEP_SUM:     step_next = STEP_VERSION;
            STEP_VERSION: step_next = STEP_KEY0;
            STEP_KEY0:    step_next = STEP_KEY1;
            STEP_KEY1:    step_next = STEP_KEY2;
            STEP_KEY2:    step_next = STEP_KEY3;
            default:      step_next = STEP_BODY;
        endcase

        if (!job_reg.last)
        begin
            last_step = STEP_BODY;
        end
        else if (job_reg.has_key)
        begin
            last_step = STEP_KEY3;
        end
        else
        begin
            last_step = STEP_VERSION;
        end

        first_step = job.body_valid ? STEP_BODY : STEP_SIZE_LO;
        done       = busy_reg && ciphertext.ready && (step_reg == last_step);
        job_ready  = !busy_reg || done;
        take       = job_valid && job_ready;

        ciphertext.valid         = busy_reg;
        ciphertext.end_of_packet = job_reg.last && (step_reg == last_step);

        unique case (step_reg)
            STEP_BODY:
            begin
                ciphertext.byte_value  = job_reg.body_value;
                ciphertext.byte_offset = job_reg.body_offset;
            end
            STEP_SIZE_LO:
            begin
                ciphertext.byte_value  = job_reg.size[7:0];
                ciphertext.byte_offset = 16'd0;
            end
            STEP_SIZE_HI:
            begin
                ciphertext.byte_value  = job_reg.size[15:8];
                ciphertext.byte_offset = 16'd1;
            end
            STEP_SUM:
            begin
                ciphertext.byte_value  = job_reg.neg_sum;
                ciphertext.byte_offset = 16'd2;
            end
            STEP_VERSION:
            begin
                ciphertext.byte_value  = VERSION_TAG;
                ciphertext.byte_offset = 16'd3;
            end
            STEP_KEY0:
            begin
                ciphertext.byte_value  = job_reg.start_key[7:0];
                ciphertext.byte_offset = 16'd8;
            end
            STEP_KEY1:
            begin
                ciphertext.byte_value  = job_reg.start_key[15:8];
                ciphertext.byte_offset = 16'd9;
            end
            STEP_KEY2:
            begin
                ciphertext.byte_value  = job_reg.start_key[23:16];
                ciphertext.byte_offset = 16'd10;
            end
            default:
            begin
                ciphertext.byte_value  = job_reg.start_key[31:24];
                ciphertext.byte_offset = 16'd11;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_BODY;
            job_reg  <= '0;
        end
        else if (take)
        begin
            busy_reg <= 1'b1;
            step_reg <= first_step;
            job_reg  <= job;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && ciphertext.ready)
        begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: rtl/packet_map_xor_chain_encrypt.sv
// Channel     Dir   Payload                                    Moves
// plaintext   in    data_byte[7:0], last                       one body byte per request
// ciphertext  out   byte_value[7:0], byte_offset[15:0], eop    one output byte per request
// cfg         in    cfg_write, cfg_index, cfg_data[31:0]       register write, no wait
//
// Sustained rate is one body byte per cycle while ciphertext is ready and no header is
// being sent. After the byte with last the header sequencer adds size, sum and version
// bytes, plus start-key bytes on the first packet; plaintext stalls meanwhile. Key chain
// update is a multiply pass, forwarded to the next byte. Reset: session key 0, packet key
// B44BB44B. Ciphertext stalls back up through one stage register and the map ROM output.
module packet_map_xor_chain_encrypt import pmx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    pmx_in_if.sink           plaintext,
    pmx_out_if.source        ciphertext,
    input  logic             cfg_write,
    input  cfg_index_t       cfg_index,
    input  logic [KEY_W-1:0] cfg_data
);

    logic [DATA_W-1:0] rom_addr;
    logic              rom_en;
    logic [DATA_W-1:0] rom_data;
    logic              job_valid;
    logic              job_ready;
    pmx_job_t          job;

    pmx_map_rom u_rom
    (
        .clk     (clk),
        .en      (rom_en),
        .addr    (rom_addr),
        .rd_data (rom_data)
    );

    pmx_cipher_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .plaintext (plaintext),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rom_addr  (rom_addr),
        .rom_en    (rom_en),
        .rom_data  (rom_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    pmx_emitter u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .ciphertext (ciphertext)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_ready |-> !plaintext.ready)
        else $error("plaintext request taken while a job is blocked");

    assert property (@(posedge clk) disable iff (!rst_n)
        ciphertext.valid && ciphertext.end_of_packet |->
            (ciphertext.byte_offset == 16'd3 || ciphertext.byte_offset == 16'd11))
        else $error("packet closed away from header or key tail");

    assert property (@(posedge clk) disable iff (!rst_n)
        ciphertext.valid && ciphertext.byte_offset == 16'd3 |->
            ciphertext.byte_value == VERSION_TAG)
        else $error("version byte corrupted");

    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_ready |=> job_valid)
        else $error("blocked job dropped");

endmodule
